>>> hdl/limited_slip_torque_split_core_assert.svh
// Assertion macros for the limited-slip torque split core.
// Used by the top level; no other dependencies.
`ifndef LIMITED_SLIP_TORQUE_SPLIT_CORE_ASSERT_SVH
`define LIMITED_SLIP_TORQUE_SPLIT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LSTS_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsts assertion failed");
// next-cycle implication
`define LSTS_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsts assertion failed");
`else
`define LSTS_IMPLIES(lbl, clk, rst_n, ante, cons)
`define LSTS_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/lsts_pkg.sv
// Shared types, constants and saturation helpers for the torque split core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lsts_pkg;
    localparam int FRAC_BITS = 16;
    localparam int DIV_STEPS = FRAC_BITS;
    // lane: diff, bias product, bias, divider steps, slow torque
    localparam int LANE_LAT  = DIV_STEPS + 4;
    localparam int PIPE      = LANE_LAT + 3;

    localparam logic [16:0] ONE_FRAC = 17'd65536;

    typedef enum logic [2:0] {
        REG_HUB       = 3'd0,
        REG_DIFF      = 3'd1,
        REG_FRAC      = 3'd2,
        REG_FRONT_MB  = 3'd3,
        REG_REAR_MB   = 3'd4,
        REG_LOCK      = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] gear;
        logic [16:0] frac;
        logic [16:0] frac_rest;
        logic [23:0] front_mb;
        logic [23:0] rear_mb;
        logic        lock;
    } t_cfg;

    typedef struct packed {
        logic signed [48:0] ax;
        logic signed [48:0] slow;
        logic               left_slow;
    } t_lane_res;

    function automatic logic signed [47:0] clamp48(input logic signed [49:0] v);
        logic signed [47:0] r;
        if (v[49:47] == 3'b000 || v[49:47] == 3'b111) begin
            r = v[47:0];
        end else if (v[49]) begin
            r = {1'b1, {47{1'b0}}};
        end else begin
            r = {1'b0, {47{1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [50:0] v);
        logic signed [31:0] r;
        if (v[50:31] == {20{1'b0}} || v[50:31] == {20{1'b1}}) begin
            r = v[31:0];
        end else if (v[50]) begin
            r = {1'b1, {31{1'b0}}};
        end else begin
            r = {1'b0, {31{1'b1}}};
        end
        return r;
    endfunction
endpackage
`default_nettype wire

>>> hdl/lsts_in_if.sv
// Input channel: drive torque and four wheel speeds.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface lsts_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive_torque;
    logic signed [31:0] front_left_speed;
    logic signed [31:0] front_right_speed;
    logic signed [31:0] rear_left_speed;
    logic signed [31:0] rear_right_speed;

    modport source (output valid, drive_torque, front_left_speed, front_right_speed,
                    rear_left_speed, rear_right_speed, input ready);
    modport sink   (input valid, drive_torque, front_left_speed, front_right_speed,
                    rear_left_speed, rear_right_speed, output ready);
endinterface
`default_nettype wire

>>> hdl/lsts_out_if.sv
// Output channel: four applied wheel torques and the driveshaft speed.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface lsts_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] front_left_torque;
    logic signed [47:0] front_right_torque;
    logic signed [47:0] rear_left_torque;
    logic signed [47:0] rear_right_torque;
    logic signed [31:0] shaft_speed;

    modport source (output valid, front_left_torque, front_right_torque,
                    rear_left_torque, rear_right_torque, shaft_speed, input ready);
    modport sink   (input valid, front_left_torque, front_right_torque,
                    rear_left_torque, rear_right_torque, shaft_speed, output ready);
endinterface
`default_nettype wire

>>> hdl/lsts_cfg.sv
// APB register file plus the registered overall gear ratio.
// Depends on lsts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lsts_cfg (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output lsts_pkg::t_cfg   o_cfg
);
    logic [23:0] r_hub, r_diff, r_fmb, r_rmb;
    logic [16:0] r_frac;
    logic        r_lock;
    logic [31:0] r_gear;
    logic [47:0] gear_prod;
    logic [16:0] frac_sat;
    logic        wr;
    lsts_pkg::t_reg_idx idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = lsts_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hub  <= 24'd65536;
            r_diff <= 24'd65536;
            r_frac <= 17'd32768;
            r_fmb  <= 24'd65536;
            r_rmb  <= 24'd65536;
            r_lock <= 1'b0;
        end else if (wr) begin
            unique case (idx)
                lsts_pkg::REG_HUB:      r_hub  <= pwdata[23:0];
                lsts_pkg::REG_DIFF:     r_diff <= pwdata[23:0];
                lsts_pkg::REG_FRAC:     r_frac <= pwdata[16:0];
                lsts_pkg::REG_FRONT_MB: r_fmb  <= pwdata[23:0];
                lsts_pkg::REG_REAR_MB:  r_rmb  <= pwdata[23:0];
                lsts_pkg::REG_LOCK:     r_lock <= pwdata[0];
                default: ;
            endcase
        end
    end

    // gear = floor(hub * diff / 2^F), registered from the ratio registers
    assign gear_prod = r_hub * r_diff;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gear <= 32'd65536;
        end else begin
            r_gear <= gear_prod[47:16];
        end
    end

    always_comb begin
        unique case (idx)
            lsts_pkg::REG_HUB:      prdata = {8'd0, r_hub};
            lsts_pkg::REG_DIFF:     prdata = {8'd0, r_diff};
            lsts_pkg::REG_FRAC:     prdata = {15'd0, r_frac};
            lsts_pkg::REG_FRONT_MB: prdata = {8'd0, r_fmb};
            lsts_pkg::REG_REAR_MB:  prdata = {8'd0, r_rmb};
            lsts_pkg::REG_LOCK:     prdata = {31'd0, r_lock};
            default:                prdata = 32'd0;
        endcase
    end

    // fractions above one act as one
    assign frac_sat = (r_frac > lsts_pkg::ONE_FRAC) ? lsts_pkg::ONE_FRAC : r_frac;

    always_comb begin
        o_cfg.gear      = r_gear;
        o_cfg.frac      = frac_sat;
        o_cfg.frac_rest = lsts_pkg::ONE_FRAC - frac_sat;
        o_cfg.front_mb  = r_fmb;
        o_cfg.rear_mb   = r_rmb;
        o_cfg.lock      = r_lock;
    end
endmodule
`default_nettype wire

>>> hdl/lsts_lane.sv
// One axle lane: speed-difference bias, pipelined bias/(1+bias) divider,
// and the slow-wheel torque product. Depends on lsts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lsts_lane (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [48:0] i_ax,
    input  wire logic signed [31:0] i_sl,
    input  wire logic signed [31:0] i_sr,
    input  wire logic        [23:0] i_max_bias,
    output lsts_pkg::t_lane_res     o_res
);
    localparam int NS = lsts_pkg::DIV_STEPS;

    // stage a: speed difference and slow side
    logic signed [32:0] d;
    logic        [32:0] n_a_diff, abs_l, abs_r;
    logic        [32:0] r_a_diff;
    logic signed [48:0] r_a_ax;
    logic               r_a_ls;
    logic        [23:0] r_a_mb;

    assign d        = $signed({i_sl[31], i_sl}) - $signed({i_sr[31], i_sr});
    assign n_a_diff = d[32] ? 33'(-d) : 33'(d);
    assign abs_l    = i_sl[31] ? 33'(-$signed({i_sl[31], i_sl})) : {1'b0, i_sl};
    assign abs_r    = i_sr[31] ? 33'(-$signed({i_sr[31], i_sr})) : {1'b0, i_sr};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_diff <= n_a_diff;
            r_a_ax   <= i_ax;
            r_a_ls   <= abs_l < abs_r;
            r_a_mb   <= i_max_bias;
        end
    end

    // stage b: (mb - 1) * diff for the linear region
    logic signed [25:0] mb_m1;
    logic signed [42:0] n_b_prod, r_b_prod;
    logic               r_b_hi, r_b_lo, r_b_ls;
    logic signed [48:0] r_b_ax;
    logic        [23:0] r_b_mb;

    assign mb_m1    = $signed({2'b00, r_a_mb}) - 26'sd65536;
    assign n_b_prod = mb_m1 * $signed({1'b0, r_a_diff[15:0]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_prod <= n_b_prod;
            r_b_hi   <= r_a_diff > 33'd32768;
            r_b_lo   <= r_a_diff > 33'd16384;
            r_b_ls   <= r_a_ls;
            r_b_ax   <= r_a_ax;
            r_b_mb   <= r_a_mb;
        end
    end

    // stage c: bias, clamped at zero; loads the divider
    logic signed [31:0] mid_val, bias_raw;
    logic        [25:0] r_rem [NS+1];
    logic        [25:0] r_den [NS+1];
    logic        [NS-1:0] r_q [NS+1];
    logic signed [48:0] r_dax [NS+1];
    logic               r_dls [NS+1];

    // floor(4 * prod / 2^F) is prod >>> (F - 2)
    assign mid_val = $signed({{3{r_b_prod[42]}}, r_b_prod[42:14]}) + 32'sd131072
                   - $signed({8'd0, r_b_mb});

    always_comb begin
        if (r_b_hi) begin
            bias_raw = $signed({8'd0, r_b_mb});
        end else if (r_b_lo) begin
            bias_raw = mid_val;
        end else begin
            bias_raw = 32'sd65536;
        end
        if (bias_raw < 0) begin
            bias_raw = 32'sd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {1'b0, bias_raw[24:0]};
            r_den[0] <= 26'(bias_raw[24:0]) + 26'd65536;
            r_q[0]   <= '0;
            r_dax[0] <= r_b_ax;
            r_dls[0] <= r_b_ls;
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar s = 0; s < NS; s++) begin : g_div
        logic [26:0] t;
        logic        ge;
        assign t  = {r_rem[s], 1'b0};
        assign ge = t >= {1'b0, r_den[s]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= ge ? 26'(t - {1'b0, r_den[s]}) : t[25:0];
                r_den[s+1] <= r_den[s];
                r_q[s+1]   <= {r_q[s][NS-2:0], ge};
                r_dax[s+1] <= r_dax[s];
                r_dls[s+1] <= r_dls[s];
            end
        end
    end

    // stage d: slow = floor(axle * alpha / 2^F)
    logic signed [65:0] slow_prod;
    assign slow_prod = r_dax[NS] * $signed({1'b0, r_q[NS]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res.ax        <= r_dax[NS];
            o_res.slow      <= slow_prod[64:16];
            o_res.left_slow <= r_dls[NS];
        end
    end
endmodule
`default_nettype wire

>>> hdl/lsts_merge.sv
// Merging stage: assigns slow/fast torques to wheels, negates, saturates,
// and holds the output register. Depends on lsts_pkg and lsts_out_if.
`timescale 1ns / 1ps
`default_nettype none
module lsts_merge (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_vld,
    input  lsts_pkg::t_lane_res     i_front,
    input  lsts_pkg::t_lane_res     i_rear,
    input  wire logic signed [31:0] i_shaft,
    output logic                    o_en,
    lsts_out_if.source              o_out
);
    logic               r_out_valid;
    logic signed [47:0] fl, fr, rl, rr;

    assign o_en        = !r_out_valid || o_out.ready;
    assign o_out.valid = r_out_valid;

    function automatic logic signed [47:0] neg_slow(input lsts_pkg::t_lane_res r);
        return lsts_pkg::clamp48(50'sd0 - $signed({r.slow[48], r.slow}));
    endfunction

    function automatic logic signed [47:0] neg_fast(input lsts_pkg::t_lane_res r);
        return lsts_pkg::clamp48($signed({r.slow[48], r.slow}) - $signed({r.ax[48], r.ax}));
    endfunction

    // ties on speed magnitude give the right wheel the slow share
    assign fl = i_front.left_slow ? neg_slow(i_front) : neg_fast(i_front);
    assign fr = i_front.left_slow ? neg_fast(i_front) : neg_slow(i_front);
    assign rl = i_rear.left_slow  ? neg_slow(i_rear)  : neg_fast(i_rear);
    assign rr = i_rear.left_slow  ? neg_fast(i_rear)  : neg_slow(i_rear);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_en) begin
            r_out_valid <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            o_out.front_left_torque  <= fl;
            o_out.front_right_torque <= fr;
            o_out.rear_left_torque   <= rl;
            o_out.rear_right_torque  <= rr;
            o_out.shaft_speed        <= i_shaft;
        end
    end
endmodule
`default_nettype wire

>>> hdl/limited_slip_torque_split_core.sv
// Top level of the limited-slip torque split core: front-end pipeline,
// two axle lanes, merge stage and APB registers. Depends on lsts_pkg,
// lsts_in_if, lsts_out_if, lsts_cfg, lsts_lane, lsts_merge.
//
//  channel | dir | handshake         | content
//  i_in    | in  | valid/ready       | drive torque, four wheel speeds (Q16.16)
//  o_out   | out | valid/ready       | four wheel torques (Q32.16), shaft speed
//  apb     | in  | psel/penable/pwrite | six config registers at 4*index
//
// One item per cycle while the output register is empty or being taken; an item passes
// S1 .. S3, the lane stages and the merge stage's output register in that order.
// The pipeline depth is set by the per-lane bias divider, one quotient bit a stage.
// Synchronous active-low reset clears all valid bits and the configuration registers.
// A full output register that is not taken freezes the whole pipeline;
// ready follows the output side, so no item is dropped or doubled.
`timescale 1ns / 1ps
`default_nettype none
`include "limited_slip_torque_split_core_assert.svh"
module limited_slip_torque_split_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    lsts_in_if.sink          i_in,
    lsts_out_if.source       o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    localparam int PIPE = lsts_pkg::PIPE;
    localparam int NDL  = lsts_pkg::LANE_LAT - 1;

    lsts_pkg::t_cfg cfg;
    logic           en;

    lsts_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign i_in.ready = en;

    // valid bit for each pipeline stage, S1 .. S23
    logic [PIPE-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE-2:0], i_in.valid};
        end
    end

    // S1: front share product t * frac, speed sums
    logic signed [49:0] n1_pf, r1_pf;
    logic signed [31:0] r1_t, r1_fl, r1_fr, r1_rl, r1_rr;
    logic signed [32:0] r1_sumf, r1_sumr;

    assign n1_pf = i_in.drive_torque * $signed({1'b0, cfg.frac});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_pf   <= n1_pf;
            r1_t    <= i_in.drive_torque;
            r1_fl   <= i_in.front_left_speed;
            r1_fr   <= i_in.front_right_speed;
            r1_rl   <= i_in.rear_left_speed;
            r1_rr   <= i_in.rear_right_speed;
            r1_sumf <= $signed({i_in.front_left_speed[31], i_in.front_left_speed})
                     + $signed({i_in.front_right_speed[31], i_in.front_right_speed});
            r1_sumr <= $signed({i_in.rear_left_speed[31], i_in.rear_left_speed})
                     + $signed({i_in.rear_right_speed[31], i_in.rear_right_speed});
        end
    end

    // S2: front/rear torque, axle-average speeds times gear (/2 folded in)
    logic signed [31:0] tqf;
    logic signed [65:0] sfp, srp;
    logic signed [31:0] r2_tqf, r2_fl, r2_fr, r2_rl, r2_rr;
    logic signed [32:0] r2_tqr;
    logic signed [48:0] r2_sf, r2_sr;

    assign tqf = r1_pf[47:16];
    assign sfp = r1_sumf * $signed({1'b0, cfg.gear});
    assign srp = r1_sumr * $signed({1'b0, cfg.gear});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_tqf <= tqf;
            r2_tqr <= $signed({r1_t[31], r1_t}) - $signed({tqf[31], tqf});
            r2_sf  <= sfp[65:17];
            r2_sr  <= srp[65:17];
            r2_fl  <= r1_fl;
            r2_fr  <= r1_fr;
            r2_rl  <= r1_rl;
            r2_rr  <= r1_rr;
        end
    end

    // S3: axle torques and weighted speeds
    logic signed [65:0] axfp, axrp;
    logic signed [66:0] wfp, wrp;
    logic signed [48:0] r3_axf, r3_axr, r3_wf, r3_wr;
    logic signed [31:0] r3_fl, r3_fr, r3_rl, r3_rr;

    assign axfp = $signed({r2_tqf[31], r2_tqf}) * $signed({1'b0, cfg.gear});
    assign axrp = r2_tqr * $signed({1'b0, cfg.gear});
    assign wfp  = r2_sf * $signed({1'b0, cfg.frac});
    assign wrp  = r2_sr * $signed({1'b0, cfg.frac_rest});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_axf <= axfp[64:16];
            r3_axr <= axrp[64:16];
            r3_wf  <= wfp[64:16];
            r3_wr  <= wrp[64:16];
            r3_fl  <= r2_fl;
            r3_fr  <= r2_fr;
            r3_rl  <= r2_rl;
            r3_rr  <= r2_rr;
        end
    end

    // S4: shaft speed, then delayed to meet the lane results
    logic signed [50:0] neg_sum;
    logic signed [31:0] r_shaft;
    logic signed [31:0] r_sh_dl [NDL];

    assign neg_sum = 51'sd0 - ($signed({{2{r3_wf[48]}}, r3_wf})
                             + $signed({{2{r3_wr[48]}}, r3_wr}));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_shaft    <= cfg.lock ? 32'sd0 : lsts_pkg::clamp32(neg_sum);
            r_sh_dl[0] <= r_shaft;
            for (int i = 1; i < NDL; i++) begin
                r_sh_dl[i] <= r_sh_dl[i-1];
            end
        end
    end

    // axle lanes
    lsts_pkg::t_lane_res front_res, rear_res;

    lsts_lane u_lane_front (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_ax       (r3_axf),
        .i_sl       (r3_fl),
        .i_sr       (r3_fr),
        .i_max_bias (cfg.front_mb),
        .o_res      (front_res)
    );

    lsts_lane u_lane_rear (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_ax       (r3_axr),
        .i_sl       (r3_rl),
        .i_sr       (r3_rr),
        .i_max_bias (cfg.rear_mb),
        .o_res      (rear_res)
    );

    lsts_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld[PIPE-1]),
        .i_front (front_res),
        .i_rear  (rear_res),
        .i_shaft (r_sh_dl[NDL-1]),
        .o_en    (en),
        .o_out   (o_out)
    );

    `LSTS_IMPLIES(a_lock_zero, i_clk, i_rst_n, o_out.valid && cfg.lock, o_out.shaft_speed == 32'sd0)
    `LSTS_NEXT(a_stall_hold, i_clk, i_rst_n, !en, $stable(r_vld))
    `LSTS_NEXT(a_accept_enters, i_clk, i_rst_n, i_in.valid && i_in.ready, r_vld[0])
    `LSTS_NEXT(a_last_to_out, i_clk, i_rst_n, en && r_vld[PIPE-1], o_out.valid)
endmodule
`default_nettype wire
